### rtl/trst_pkg.sv
// shared constants, register codes and the arctangent table of the touch ring tracker
`default_nettype none

package trst_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 24;

    localparam int ARC_W      = 16;
    localparam int COUNT_W    = 6;
    localparam int MASK_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ARC_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 2'd2;

    localparam logic FUNC_CONTACT = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // atan(2^-i) in binary angle, 2^32 per turn
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### rtl/touch_ring_sector_tracker.sv
// touch ring tracker: cordic angle, arc test, segment divide and tick masks
// contact word: accepted, then cordic iterations, a map step, divide steps and an update step;
//   the next word is taken once the sequencer is back in idle (a zero offset skips the cordic,
//   a contact off the arc ends after the map step, an empty arc or zero segment count drops it)
// tick word: its result sits in the output register the next cycle
// the cordic iteration and the one-bit-a-cycle restoring divider make up the contact path
// reset: async active low; arcs 0..65535, 8 segments, segment marks cleared, no result pending
`default_nettype none

module touch_ring_sector_tracker (
    input  wire                               clk,
    input  wire                               rst_n,
    // configuration write port
    input  wire                               cfg_wr_en,
    input  wire [trst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [trst_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               func,
    input  wire signed [trst_pkg::COORD_BITS-1:0] contact_dx,
    input  wire signed [trst_pkg::COORD_BITS-1:0] contact_dy,
    // output channel
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [trst_pkg::MASK_W-1:0]       held_mask,
    output logic [trst_pkg::MASK_W-1:0]       pressed_mask,
    output logic [trst_pkg::MASK_W-1:0]       released_mask,
    output logic                              changed
);
    import trst_pkg::*;

    // cordic datapath width: sign, negation of the most negative input and gain headroom
    localparam int CW       = COORD_BITS + 4;
    localparam int PROD_W   = ANGLE_BITS + COUNT_W;
    localparam int EXT_W    = ANGLE_BITS + ARC_W;
    localparam int SCALE_UP = (ANGLE_BITS >= ARC_W) ? ANGLE_BITS - ARC_W : 0;
    localparam int SCALE_DN = (ANGLE_BITS <  ARC_W) ? ARC_W - ANGLE_BITS : 0;
    localparam int SEG_LIM  = (MAX_SEGMENTS < MASK_W) ? MAX_SEGMENTS : MASK_W;
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int KBIT_W   = $clog2(COUNT_W);
    localparam int SEG_W    = $clog2(MASK_W);

    localparam logic [COUNT_W-1:0] SEG_LIMIT = COUNT_W'(SEG_LIM);
    localparam logic [31:0]        Z_ROUND   = 32'(1) << (31 - ANGLE_BITS);
    localparam logic [31:0]        Z_HALF    = 32'h80000000;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0]  K_FIRST   = STEP_W'(COUNT_W - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CORDIC = 3'd1;
    localparam logic [2:0] ST_MAP    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // configuration registers
    logic [ARC_W-1:0]    arc_start_reg, arc_start_next;
    logic [ARC_W-1:0]    arc_end_reg, arc_end_next;
    logic [COUNT_W-1:0]  seg_count_reg, seg_count_next;

    // segment marks
    logic [MASK_W-1:0]   held_reg, held_next;
    logic [MASK_W-1:0]   prev_reg, prev_next;
    logic [MASK_W-1:0]   cur_reg, cur_next;
    logic [MASK_W-1:0]   new_reg, new_next;

    // result word register
    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   held_out_reg, held_out_next;
    logic [MASK_W-1:0]   pressed_out_reg, pressed_out_next;
    logic [MASK_W-1:0]   released_out_reg, released_out_next;
    logic                changed_reg, changed_next;

    // datapath registers, no reset
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic [31:0]          z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [ANGLE_BITS-1:0] span_reg, span_next;
    logic [COUNT_W-1:0]   quo_reg, quo_next;

    // combinational helpers
    logic [EXT_W-1:0]      lo_ext, hi_ext;
    logic [ANGLE_BITS-1:0] lo, hi;
    logic [COUNT_W-1:0]    n_eff;
    logic                  arc_ok;
    logic                  in_accept, out_accept;
    logic                  tick_accept, contact_start;
    logic signed [CW-1:0]  dx_ext, dy_ext;
    logic signed [CW-1:0]  xs, ys;
    logic [31:0]           atan_val;
    logic [31:0]           z_rounded;
    logic [ANGLE_BITS-1:0] angle, offset, span;
    logic [PROD_W-1:0]     product, trial;
    logic                  fits;
    logic [COUNT_W-1:0]    seg;
    logic [MASK_W-1:0]     seg_bit;
    logic [MASK_W-1:0]     released;
    logic                  cfg_hit;

    // arc registers scaled to the angle width
    assign lo_ext = (EXT_W'(arc_start_reg) << SCALE_UP) >> SCALE_DN;
    assign hi_ext = (EXT_W'(arc_end_reg) << SCALE_UP) >> SCALE_DN;
    assign lo     = lo_ext[ANGLE_BITS-1:0];
    assign hi     = hi_ext[ANGLE_BITS-1:0];
    assign n_eff  = (seg_count_reg > SEG_LIMIT) ? SEG_LIMIT : seg_count_reg;
    // empty arc or no segments: contacts fall through untouched
    assign arc_ok = (n_eff != '0) && (lo != hi);

    // a tick needs the result register free, a contact does not
    assign in_stall    = (state_reg != ST_IDLE) ||
                         ((func == FUNC_TICK) && out_valid_reg && out_stall);
    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid_reg && !out_stall;
    assign tick_accept = in_accept && (func == FUNC_TICK);
    assign contact_start = in_accept && (func == FUNC_CONTACT) && arc_ok;

    assign dx_ext = {{(CW-COORD_BITS){contact_dx[COORD_BITS-1]}}, contact_dx};
    assign dy_ext = {{(CW-COORD_BITS){contact_dy[COORD_BITS-1]}}, contact_dy};

    // shared cordic rotation: floor shifts and one table entry per cycle
    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign atan_val = atan_entry(5'(step_reg));

    // round to nearest, ties up, wrapping past a full turn
    assign z_rounded = z_reg + Z_ROUND;
    assign angle     = zero_reg ? '0 : z_rounded[31 -: ANGLE_BITS];
    assign offset    = angle - lo;
    // same modular difference whether or not the arc wraps
    assign span      = hi - lo;
    assign product   = PROD_W'(offset) * PROD_W'(n_eff);

    // restoring divide: one quotient bit a cycle, msb first
    assign trial = PROD_W'(span_reg) << step_reg[KBIT_W-1:0];
    assign fits  = (rem_reg >= trial);

    // hit exactly at the arc end goes to the last segment
    assign seg     = (quo_reg >= n_eff) ? (n_eff - COUNT_W'(1)) : quo_reg;
    assign seg_bit = MASK_W'(1) << seg[SEG_W-1:0];

    assign released = prev_reg & ~cur_reg;

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            CFG_ARC_START, CFG_ARC_END, CFG_SEG_COUNT: cfg_hit = cfg_wr_en;
            default:                                   cfg_hit = 1'b0;
        endcase
    end

    // sequencer and datapath
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        rem_next   = rem_reg;
        span_next  = span_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (contact_start)
                begin
                    step_next = '0;
                    zero_next = (contact_dx == '0) && (contact_dy == '0);
                    if (contact_dx[COORD_BITS-1])
                    begin
                        x_next = -dx_ext;
                        y_next = -dy_ext;
                        z_next = Z_HALF;
                    end
                    else
                    begin
                        x_next = dx_ext;
                        y_next = dy_ext;
                        z_next = '0;
                    end
                    // zero offset skips the rotation, angle is zero
                    state_next = ((contact_dx == '0) && (contact_dy == '0)) ? ST_MAP : ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (!y_reg[CW-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_val;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_val;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (offset > span)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_next   = product;
                    span_next  = span;
                    quo_next   = '0;
                    step_next  = K_FIRST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - trial;
                end
                quo_next  = {quo_reg[COUNT_W-2:0], fits};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, marks and result word
    always_comb
    begin
        arc_start_next    = arc_start_reg;
        arc_end_next      = arc_end_reg;
        seg_count_next    = seg_count_reg;
        held_next         = held_reg;
        prev_next         = prev_reg;
        cur_next          = cur_reg;
        new_next          = new_reg;
        out_valid_next    = out_valid_reg && !out_accept;
        held_out_next     = held_out_reg;
        pressed_out_next  = pressed_out_reg;
        released_out_next = released_out_reg;
        changed_next      = changed_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ARC_START: arc_start_next = cfg_data[ARC_W-1:0];
                CFG_ARC_END:   arc_end_next   = cfg_data[ARC_W-1:0];
                CFG_SEG_COUNT: seg_count_next = cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end

        if (cfg_hit)
        begin
            // a reconfigured ring starts untouched
            held_next = '0;
            prev_next = '0;
            cur_next  = '0;
            new_next  = '0;
        end
        else if (tick_accept)
        begin
            held_next         = held_reg & ~released;
            prev_next         = cur_reg;
            cur_next          = '0;
            new_next          = '0;
            out_valid_next    = 1'b1;
            held_out_next     = held_reg & ~released;
            pressed_out_next  = new_reg;
            released_out_next = released;
            changed_next      = (new_reg != '0) || (released != '0);
        end
        else if (state_reg == ST_UPD)
        begin
            cur_next = cur_reg | seg_bit;
            if ((held_reg & seg_bit) == '0)
            begin
                held_next = held_reg | seg_bit;
                new_next  = new_reg | seg_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            arc_start_reg <= '0;
            arc_end_reg   <= {ARC_W{1'b1}};
            seg_count_reg <= COUNT_W'(8);
            held_reg      <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            new_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            arc_start_reg <= arc_start_next;
            arc_end_reg   <= arc_end_next;
            seg_count_reg <= seg_count_next;
            held_reg      <= held_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            new_reg       <= new_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        z_reg            <= z_next;
        zero_reg         <= zero_next;
        rem_reg          <= rem_next;
        span_reg         <= span_next;
        quo_reg          <= quo_next;
        held_out_reg     <= held_out_next;
        pressed_out_reg  <= pressed_out_next;
        released_out_reg <= released_out_next;
        changed_reg      <= changed_next;
    end

    assign out_valid     = out_valid_reg;
    assign held_mask     = held_out_reg;
    assign pressed_mask  = pressed_out_reg;
    assign released_mask = released_out_reg;
    assign changed       = changed_reg;

endmodule

`default_nettype wire
